// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the bracket balance checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- src/bbc_pkg.sv -----
// Types, codes and bracket decoding for the bracket balance checker.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  typedef logic [1:0] kind_t;

  localparam logic [7:0] ChOpenParen   = 8'h28;
  localparam logic [7:0] ChOpenSquare  = 8'h5B;
  localparam logic [7:0] ChOpenCurly   = 8'h7B;
  localparam logic [7:0] ChOpenAngle   = 8'h3C;
  localparam logic [7:0] ChCloseParen  = 8'h29;
  localparam logic [7:0] ChCloseSquare = 8'h5D;
  localparam logic [7:0] ChCloseCurly  = 8'h7D;
  localparam logic [7:0] ChCloseAngle  = 8'h3E;

  localparam kind_t KindParen  = 2'd0;
  localparam kind_t KindSquare = 2'd1;
  localparam kind_t KindCurly  = 2'd2;
  localparam kind_t KindAngle  = 2'd3;

  localparam logic [1:0] StatBalanced   = 2'd0;
  localparam logic [1:0] StatCorrupt    = 2'd1;
  localparam logic [1:0] StatIncomplete = 2'd2;
  localparam logic [1:0] StatOverflow   = 2'd3;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } sym_class_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KindParen};
    case (sym)
      ChOpenParen:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KindParen};
      ChOpenSquare:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KindSquare};
      ChOpenCurly:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KindCurly};
      ChOpenAngle:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KindAngle};
      ChCloseParen:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KindParen};
      ChCloseSquare: c = '{is_open: 1'b0, is_close: 1'b1, kind: KindSquare};
      ChCloseCurly:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KindCurly};
      ChCloseAngle:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KindAngle};
      default:       c = '{is_open: 1'b0, is_close: 1'b0, kind: KindParen};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] closer_of(input kind_t kind);
    logic [7:0] ch;
    case (kind)
      KindParen:  ch = ChCloseParen;
      KindSquare: ch = ChCloseSquare;
      KindCurly:  ch = ChCloseCurly;
      KindAngle:  ch = ChCloseAngle;
      default:    ch = ChCloseParen;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- src/bracket_balance_checker_core.sv -----
// Top level of the bracket balance checker: stack control around the stack RAM.
//
//   channel | direction | payload                    | handshake
//   in      | input     | symbol, end_of_line        | in_valid_i / in_ready_o
//   out     | output     | status, character, last    | out_valid_o / out_ready_i
//
// One byte per cycle outside a drain; the stack RAM is read one entry below the
// next level every cycle, and a push seen last cycle is forwarded past the RAM.
// A line end with N open brackets drains as N results, one RAM read per closer;
// no input is taken meanwhile. Other line ends produce one result.
// Reset leaves the RAM contents undefined; only entries below the level are used.
// A line-end byte stalls while the output register holds an untaken result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bracket_balance_checker_core import bbc_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       end_of_line_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [1:0] status_o,
  output logic      [7:0] character_o,
  output logic            last_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e     state_q, state_d;
  logic [LW-1:0] level_q, level_d;
  logic       corrupt_q, corrupt_d;
  logic       overflow_q, overflow_d;
  logic [7:0] illegal_q, illegal_d;
  logic       fwd_valid_q, fwd_valid_d;
  kind_t      fwd_kind_q, fwd_kind_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  kind_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  kind_t         ram_rdata;
  logic [LW-1:0] level_below;

  sym_class_t cls;
  kind_t      top_kind;
  logic       out_free;
  logic       in_fire;

  bbc_ram #(
    .Width (2),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cls         = classify(symbol_i);
  assign top_kind    = fwd_valid_q ? fwd_kind_q : ram_rdata;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_RUN) && (out_free || !end_of_line_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign level_below = level_d - LW'(1);
  assign ram_raddr   = level_below[AW-1:0];
  assign ram_waddr   = level_q[AW-1:0];
  assign ram_wdata   = cls.kind;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    corrupt_d   = corrupt_q;
    overflow_d  = overflow_q;
    illegal_d   = illegal_q;
    fwd_valid_d = 1'b0;
    fwd_kind_d  = fwd_kind_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    char_d      = char_q;
    last_d      = last_q;
    ram_we      = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          if (!corrupt_q && !overflow_q) begin
            if (cls.is_open) begin
              if (level_q == LW'(STACK_DEPTH)) begin
                overflow_d = 1'b1;
              end else begin
                ram_we      = 1'b1;
                level_d     = level_q + LW'(1);
                fwd_valid_d = 1'b1;
                fwd_kind_d  = cls.kind;
              end
            end else if (cls.is_close) begin
              if (level_q == '0 || top_kind != cls.kind) begin
                corrupt_d = 1'b1;
                illegal_d = symbol_i;
              end else begin
                level_d = level_q - LW'(1);
              end
            end
          end
          if (end_of_line_i) begin
            if (!overflow_d && !corrupt_d && level_d != '0) begin
              state_d = ST_DRAIN;
            end else begin
              out_valid_d = 1'b1;
              last_d      = 1'b1;
              if (overflow_d) begin
                status_d = StatOverflow;
                char_d   = '0;
              end else if (corrupt_d) begin
                status_d = StatCorrupt;
                char_d   = illegal_d;
              end else begin
                status_d = StatBalanced;
                char_d   = '0;
              end
              level_d    = '0;
              corrupt_d  = 1'b0;
              overflow_d = 1'b0;
              illegal_d  = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = StatIncomplete;
          char_d      = closer_of(top_kind);
          last_d      = (level_q == LW'(1));
          level_d     = level_q - LW'(1);
          if (level_q == LW'(1)) begin
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      level_q     <= '0;
      corrupt_q   <= 1'b0;
      overflow_q  <= 1'b0;
      illegal_q   <= '0;
      fwd_valid_q <= 1'b0;
      fwd_kind_q  <= KindParen;
      out_valid_q <= 1'b0;
      status_q    <= StatBalanced;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      corrupt_q   <= corrupt_d;
      overflow_q  <= overflow_d;
      illegal_q   <= illegal_d;
      fwd_valid_q <= fwd_valid_d;
      fwd_kind_q  <= fwd_kind_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  `ASSERT_ALWAYS(a_level_in_range, clk_i, rst_ni, level_q <= LW'(STACK_DEPTH))
  `ASSERT_IMPLIES(a_drain_clean, clk_i, rst_ni, state_q == ST_DRAIN,
                  level_q != '0 && !corrupt_q && !overflow_q)
  `ASSERT_IMPLIES(a_single_is_last, clk_i, rst_ni,
                  out_valid_q && status_q != StatIncomplete, last_q)

endmodule

`default_nettype wire

// ----- src/bbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
  parameter int Width = 2,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
